// File: design/spq_pkg.sv
// Package for the stable priority queue.
// Command and result word types, operation and status codes, controller states.
// No dependencies.
package spq_pkg;

  localparam int STAMP_BITS = 32;

  localparam logic MODE_PUSH = 1'b0;
  localparam logic MODE_POP  = 1'b1;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_POP_EMPTY = 2'd1;
  localparam logic [1:0] ST_PUSH_FULL = 2'd2;

  typedef struct packed {
    logic        mode;
    logic [15:0] payload;
    logic [15:0] priority_req;
  } cmd_word_t;

  typedef struct packed {
    logic [15:0] head_payload;
    logic [15:0] head_priority;
    logic [4:0]  entry_count;
    logic        is_empty;
    logic [1:0]  status;
  } result_word_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_FINISH
  } ctrl_state_t;

endpackage

// File: design/stable_priority_queue.sv
// Stable bounded priority queue, ties served first-in first-out.
// Depends on spq_pkg and spq_ram (entry store).
//
//   channel | ports                 | handshake
//   --------+-----------------------+----------------------------------
//   command | cmd (cmd_word_t)      | taken when start && !busy
//   result  | result (result_word_t)| valid for one cycle while done
//
// A push or pop that changes the queue scans the entry RAM one slot per cycle;
// busy stays high through the scan and finish states, and done is registered in finish.
// A push to a full queue or a pop on an empty queue answers in the next cycle.
// After reset a clearing pass writes zero to every RAM slot and holds busy high.
// The receiver cannot stall; each result is shown once.
module stable_priority_queue #(
  parameter int DEPTH         = 16,
  parameter int PAYLOAD_BITS  = 16,
  parameter int PRIORITY_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  spq_pkg::cmd_word_t   cmd,
  output logic                 done,
  output spq_pkg::result_word_t result
);

  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int SB     = spq_pkg::STAMP_BITS;
  localparam int WORD_W = 1 + PAYLOAD_BITS + PRIORITY_BITS + SB;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  spq_pkg::ctrl_state_t state, state_next;

  logic [IDX_W-1:0]         cnt;
  logic                     issue_done;
  logic                     rd_vld;
  logic [IDX_W-1:0]         rd_idx;
  logic [CNT_W-1:0]         count;
  logic [SB-1:0]            stamp;
  spq_pkg::cmd_word_t       cmd_reg;
  logic [1:0]               status;

  logic [IDX_W-1:0]         head_idx;
  logic [PAYLOAD_BITS-1:0]  head_pay;
  logic [PRIORITY_BITS-1:0] head_pri;

  logic                     best_found;
  logic [IDX_W-1:0]         best_idx;
  logic [PAYLOAD_BITS-1:0]  best_pay;
  logic [PRIORITY_BITS-1:0] best_pri;
  logic [SB-1:0]            best_age;
  logic                     free_found;
  logic [IDX_W-1:0]         free_idx;

  logic                     we;
  logic [IDX_W-1:0]         waddr;
  logic [WORD_W-1:0]        wdata;
  logic [WORD_W-1:0]        rdata;
  logic                     accept;
  logic                     cmd_push;

  logic                     rd_valid_bit;
  logic [PAYLOAD_BITS-1:0]  rd_pay;
  logic [PRIORITY_BITS-1:0] rd_pri;
  logic [SB-1:0]            rd_stamp;
  logic [SB-1:0]            rd_age;
  logic                     rd_better;

  logic [PAYLOAD_BITS+15:0]  in_pay_ext;
  logic [PRIORITY_BITS+15:0] in_pri_ext;
  logic [PAYLOAD_BITS+15:0]  out_pay_ext;
  logic [PRIORITY_BITS+15:0] out_pri_ext;
  logic [CNT_W+4:0]          out_cnt_ext;
  logic [PAYLOAD_BITS-1:0]   new_pay;
  logic [PRIORITY_BITS-1:0]  new_pri;
  logic [SB-1:0]             stamp_inc;

  spq_ram #(.WIDTH(WORD_W), .DEPTH(DEPTH)) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (cnt),
    .rdata (rdata)
  );

  assign accept   = start && !busy;
  assign cmd_push = cmd_reg.mode == spq_pkg::MODE_PUSH;

  assign in_pay_ext = (PAYLOAD_BITS + 16)'(cmd_reg.payload);
  assign in_pri_ext = (PRIORITY_BITS + 16)'(cmd_reg.priority_req);
  assign new_pay    = in_pay_ext[PAYLOAD_BITS-1:0];
  assign new_pri    = in_pri_ext[PRIORITY_BITS-1:0];
  assign stamp_inc  = stamp + SB'(1);

  assign {rd_valid_bit, rd_pay, rd_pri, rd_stamp} = rdata;
  assign rd_age    = stamp - rd_stamp;
  assign rd_better = rd_valid_bit && (!best_found || rd_pri < best_pri ||
                     (rd_pri == best_pri && rd_age > best_age));

  // next state
  always_comb begin
    state_next = state;
    case (state)
      spq_pkg::S_CLEAR: begin
        if (cnt == LAST_IDX) state_next = spq_pkg::S_IDLE;
      end
      spq_pkg::S_IDLE: begin
        if (accept) begin
          if (cmd.mode == spq_pkg::MODE_PUSH) begin
            if (count != FULL_CNT) state_next = spq_pkg::S_SCAN;
          end else if (count != '0) begin
            state_next = spq_pkg::S_SCAN;
          end
        end
      end
      spq_pkg::S_SCAN: begin
        if (rd_vld && rd_idx == LAST_IDX) state_next = spq_pkg::S_FINISH;
      end
      spq_pkg::S_FINISH: state_next = spq_pkg::S_IDLE;
      default: state_next = spq_pkg::S_CLEAR;
    endcase
  end

  // RAM write port and busy
  always_comb begin
    we    = 1'b0;
    waddr = cnt;
    wdata = '0;
    busy  = state != spq_pkg::S_IDLE;
    case (state)
      spq_pkg::S_CLEAR: we = 1'b1;
      spq_pkg::S_IDLE: begin
        if (accept && cmd.mode == spq_pkg::MODE_POP && count != '0) begin
          we    = 1'b1;
          waddr = head_idx;
        end
      end
      spq_pkg::S_FINISH: begin
        if (cmd_push) begin
          we    = 1'b1;
          waddr = free_idx;
          wdata = {1'b1, new_pay, new_pri, stamp_inc};
        end
      end
      default: we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= spq_pkg::S_CLEAR;
      cnt        <= '0;
      issue_done <= 1'b0;
      rd_vld     <= 1'b0;
      count      <= '0;
      stamp      <= '0;
      done       <= 1'b0;
      status     <= spq_pkg::ST_OK;
    end else begin
      state  <= state_next;
      rd_vld <= state == spq_pkg::S_SCAN && !issue_done;
      rd_idx <= cnt;
      case (state)
        spq_pkg::S_CLEAR: begin
          done <= 1'b0;
          cnt  <= (cnt == LAST_IDX) ? '0 : cnt + IDX_W'(1);
        end
        spq_pkg::S_IDLE: begin
          cnt        <= '0;
          issue_done <= 1'b0;
          best_found <= 1'b0;
          best_age   <= '0;
          free_found <= 1'b0;
          done       <= accept && ((cmd.mode == spq_pkg::MODE_PUSH) ?
                                   (count == FULL_CNT) : (count == '0));
          if (accept) begin
            cmd_reg <= cmd;
            if (cmd.mode == spq_pkg::MODE_PUSH) begin
              status <= (count == FULL_CNT) ? spq_pkg::ST_PUSH_FULL : spq_pkg::ST_OK;
            end else if (count == '0) begin
              status <= spq_pkg::ST_POP_EMPTY;
            end else begin
              status <= spq_pkg::ST_OK;
              count  <= count - CNT_W'(1);
            end
          end
        end
        spq_pkg::S_SCAN: begin
          done <= 1'b0;
          if (!issue_done) begin
            if (cnt == LAST_IDX) issue_done <= 1'b1;
            else cnt <= cnt + IDX_W'(1);
          end
          if (rd_vld) begin
            if (cmd_push) begin
              if (!rd_valid_bit && !free_found) begin
                free_found <= 1'b1;
                free_idx   <= rd_idx;
              end
            end else if (rd_better) begin
              best_found <= 1'b1;
              best_idx   <= rd_idx;
              best_pay   <= rd_pay;
              best_pri   <= rd_pri;
              best_age   <= rd_age;
            end
          end
        end
        spq_pkg::S_FINISH: begin
          done <= 1'b1;
          if (cmd_push) begin
            stamp <= stamp_inc;
            count <= count + CNT_W'(1);
            if (count == '0 || new_pri < head_pri) begin
              head_idx <= free_idx;
              head_pay <= new_pay;
              head_pri <= new_pri;
            end
          end else if (best_found) begin
            head_idx <= best_idx;
            head_pay <= best_pay;
            head_pri <= best_pri;
          end
        end
        default: begin
          cnt  <= '0;
          done <= 1'b0;
        end
      endcase
    end
  end

  assign out_pay_ext = (PAYLOAD_BITS + 16)'(head_pay);
  assign out_pri_ext = (PRIORITY_BITS + 16)'(head_pri);
  assign out_cnt_ext = (CNT_W + 5)'(count);

  always_comb begin
    result.head_payload  = (count == '0) ? 16'd0 : out_pay_ext[15:0];
    result.head_priority = (count == '0) ? 16'd0 : out_pri_ext[15:0];
    result.entry_count   = out_cnt_ext[4:0];
    result.is_empty      = count == '0;
    result.status        = status;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_CNT)
    else $error("entry count above depth");

  a_full_flag: assert property (@(posedge clk) disable iff (rst)
    done && status == spq_pkg::ST_PUSH_FULL |-> count == FULL_CNT)
    else $error("push dropped while not full");

  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    done && status == spq_pkg::ST_POP_EMPTY |-> count == '0)
    else $error("pop flagged empty while entries held");

  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy || done)
    else $error("command neither answered nor in progress");

  a_scan_free: assert property (@(posedge clk) disable iff (rst)
    state == spq_pkg::S_FINISH && cmd_push |-> free_found)
    else $error("push finished without a free slot");

endmodule

// File: design/spq_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module spq_ram #(
  parameter int WIDTH = 65,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
